/* rtl/ptsd_pkg.sv */
// Package: widths, region codes, register indexes and side-band types for the segment distance block
`timescale 1ns / 1ps
package ptsd_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DOT_W     = PROD_W + 1;
  localparam int LEN_W     = PROD_W;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int FOOT_W    = T_W + 1 + DIFF_W;
  localparam int OFS_W     = FOOT_W - FRAC_BITS;
  localparam int ERR_W     = OFS_W + 1;
  localparam int SQ_W      = 2 * ERR_W;
  localparam int RAD_W     = SQ_W + 2;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int DIST_W    = 33;

  localparam logic [1:0] CFG_START_X = 2'd0;
  localparam logic [1:0] CFG_START_Y = 2'd1;
  localparam logic [1:0] CFG_END_X   = 2'd2;
  localparam logic [1:0] CFG_END_Y   = 2'd3;

  typedef enum logic [1:0] {
    REG_FOOT  = 2'd0,
    REG_START = 2'd1,
    REG_END   = 2'd2,
    REG_DEGEN = 2'd3
  } region_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] ax;
    logic signed [DIFF_W-1:0] ay;
    logic signed [DIFF_W-1:0] bx;
    logic signed [DIFF_W-1:0] by;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    region_t                  region;
    logic                     eq;
  } div_side_t;

endpackage

/* rtl/ptsd_div.sv */
// Pipelined restoring divider: one quotient bit per stage for the projection parameter
`timescale 1ns / 1ps
module ptsd_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [ptsd_pkg::LEN_W-1:0]        in_rem,
  input  logic [ptsd_pkg::LEN_W-1:0]        in_den,
  input  ptsd_pkg::div_side_t               in_side,
  output logic                              out_valid,
  output logic [ptsd_pkg::FRAC_BITS-1:0]    out_quot,
  output ptsd_pkg::div_side_t               out_side
);

  localparam int N = ptsd_pkg::FRAC_BITS;
  localparam int W = ptsd_pkg::LEN_W;

  logic [N:0]                   vld;
  logic [W-1:0]                 rem [0:N];
  logic [W-1:0]                 den [0:N];
  logic [N-1:0]                 quo [0:N];
  ptsd_pkg::div_side_t          side [0:N];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_rem;
  assign den[0]  = in_den;
  assign quo[0]  = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [W:0]   shifted;
    logic         ge;
    logic [W:0]   diff;

    assign shifted = {rem[k], 1'b0};
    assign ge      = shifted >= {1'b0, den[k]};
    assign diff    = shifted - {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? diff[W-1:0] : shifted[W-1:0];
        den[k+1]  <= den[k];
        quo[k+1]  <= {quo[k][N-2:0], ge};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_quot  = quo[N];
  assign out_side  = side[N];

endmodule

/* rtl/ptsd_sqrt.sv */
// Pipelined floor square root: one root bit per stage
`timescale 1ns / 1ps
module ptsd_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [ptsd_pkg::RAD_W-1:0]      in_rad,
  input  ptsd_pkg::region_t               in_region,
  output logic                            out_valid,
  output logic [ptsd_pkg::ROOT_W-1:0]     out_root,
  output ptsd_pkg::region_t               out_region
);

  localparam int N = ptsd_pkg::ROOT_W;
  localparam int W = ptsd_pkg::RAD_W;

  logic [N:0]               vld;
  logic [W-1:0]             rem  [0:N];
  logic [N-1:0]             root [0:N];
  ptsd_pkg::region_t        reg_q [0:N];

  assign vld[0]   = in_valid;
  assign rem[0]   = in_rad;
  assign root[0]  = '0;
  assign reg_q[0] = in_region;

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int B = N - 1 - k;
    logic [W-1:0] trial;
    logic         ge;

    assign trial = (W'(root[k]) << (B + 1)) | (W'(1) << (2 * B));
    assign ge    = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]   <= ge ? rem[k] - trial : rem[k];
        root[k+1]  <= ge ? (root[k] | (N'(1) << B)) : root[k];
        reg_q[k+1] <= reg_q[k];
      end
    end
  end

  assign out_valid  = vld[N];
  assign out_root   = root[N];
  assign out_region = reg_q[N];

endmodule

/* rtl/point_to_segment_distance.sv */
// Top level: distance from a probe point to a configured line segment
// Pipeline: 4 setup stages, 16 divider stages, 4 foot and square stages, 37 square-root
//   stages and an output register.
// Throughput: one probe per cycle; the whole pipeline holds while the output stalls.
// Reset: synchronous, clears the segment registers to zero and all stage valid bits.
`timescale 1ns / 1ps
module point_to_segment_distance (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [ptsd_pkg::COORD_W-1:0]        cfg_data,
  input  logic                                probe_valid,
  output logic                                probe_stall,
  input  logic signed [ptsd_pkg::COORD_W-1:0] probe_x,
  input  logic signed [ptsd_pkg::COORD_W-1:0] probe_y,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [ptsd_pkg::DIST_W-1:0]         distance,
  output logic [1:0]                          nearest_region
);

  localparam int CW = ptsd_pkg::COORD_W;
  localparam int DW = ptsd_pkg::DIFF_W;
  localparam int FB = ptsd_pkg::FRAC_BITS;

  logic signed [CW-1:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
  logic                 en;

  assign cfg_ready   = 1'b1;
  assign en          = !result_valid || !result_stall;
  assign probe_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_start_x <= '0;
      seg_start_y <= '0;
      seg_end_x   <= '0;
      seg_end_y   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ptsd_pkg::CFG_START_X: seg_start_x <= cfg_data;
        ptsd_pkg::CFG_START_Y: seg_start_y <= cfg_data;
        ptsd_pkg::CFG_END_X:   seg_end_x   <= cfg_data;
        ptsd_pkg::CFG_END_Y:   seg_end_y   <= cfg_data;
        default:               seg_end_y   <= seg_end_y;
      endcase
    end
  end

  // stage 1: differences
  logic                 s1_v;
  logic signed [DW-1:0] s1_ax, s1_ay, s1_bx, s1_by, s1_dx, s1_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= probe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax <= {probe_x[CW-1], probe_x} - {seg_start_x[CW-1], seg_start_x};
      s1_ay <= {probe_y[CW-1], probe_y} - {seg_start_y[CW-1], seg_start_y};
      s1_bx <= {probe_x[CW-1], probe_x} - {seg_end_x[CW-1], seg_end_x};
      s1_by <= {probe_y[CW-1], probe_y} - {seg_end_y[CW-1], seg_end_y};
      s1_dx <= {seg_end_x[CW-1], seg_end_x} - {seg_start_x[CW-1], seg_start_x};
      s1_dy <= {seg_end_y[CW-1], seg_end_y} - {seg_start_y[CW-1], seg_start_y};
    end
  end

  // stage 2: products
  logic                                s2_v, s2_degen;
  logic signed [ptsd_pkg::PROD_W-1:0]  s2_pxx, s2_pyy, s2_qxx, s2_qyy;
  logic signed [DW-1:0]                s2_ax, s2_ay, s2_bx, s2_by, s2_dx, s2_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pxx   <= s1_ax * s1_dx;
      s2_pyy   <= s1_ay * s1_dy;
      s2_qxx   <= s1_dx * s1_dx;
      s2_qyy   <= s1_dy * s1_dy;
      s2_degen <= (s1_dx == '0) && (s1_dy == '0);
      s2_ax    <= s1_ax;
      s2_ay    <= s1_ay;
      s2_bx    <= s1_bx;
      s2_by    <= s1_by;
      s2_dx    <= s1_dx;
      s2_dy    <= s1_dy;
    end
  end

  // stage 3: dot product and squared length
  logic                               s3_v, s3_degen;
  logic [ptsd_pkg::DOT_W-1:0]         s3_dot;
  logic [ptsd_pkg::LEN_W-1:0]         s3_len2;
  logic signed [DW-1:0]               s3_ax, s3_ay, s3_bx, s3_by, s3_dx, s3_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_dot   <= {s2_pxx[ptsd_pkg::PROD_W-1], s2_pxx} + {s2_pyy[ptsd_pkg::PROD_W-1], s2_pyy};
      s3_len2  <= s2_qxx + s2_qyy;
      s3_degen <= s2_degen;
      s3_ax    <= s2_ax;
      s3_ay    <= s2_ay;
      s3_bx    <= s2_bx;
      s3_by    <= s2_by;
      s3_dx    <= s2_dx;
      s3_dy    <= s2_dy;
    end
  end

  // stage 4: region decision
  logic                        s4_v;
  logic [ptsd_pkg::LEN_W-1:0]  s4_rem, s4_len2;
  ptsd_pkg::div_side_t         s4_side;
  ptsd_pkg::region_t           s3_region;

  always_comb begin
    priority if (s3_degen) begin
      s3_region = ptsd_pkg::REG_DEGEN;
    end else if (s3_dot[ptsd_pkg::DOT_W-1]) begin
      s3_region = ptsd_pkg::REG_START;
    end else if (s3_dot[ptsd_pkg::LEN_W-1:0] > s3_len2) begin
      s3_region = ptsd_pkg::REG_END;
    end else begin
      s3_region = ptsd_pkg::REG_FOOT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_rem         <= s3_dot[ptsd_pkg::LEN_W-1:0];
      s4_len2        <= s3_len2;
      s4_side.ax     <= s3_ax;
      s4_side.ay     <= s3_ay;
      s4_side.bx     <= s3_bx;
      s4_side.by     <= s3_by;
      s4_side.dx     <= s3_dx;
      s4_side.dy     <= s3_dy;
      s4_side.region <= s3_region;
      s4_side.eq     <= s3_dot == {1'b0, s3_len2};
    end
  end

  logic                  dv;
  logic [FB-1:0]         dq;
  ptsd_pkg::div_side_t   ds;

  ptsd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_v),
    .in_rem    (s4_rem),
    .in_den    (s4_len2),
    .in_side   (s4_side),
    .out_valid (dv),
    .out_quot  (dq),
    .out_side  (ds)
  );

  // stage 5: foot offset products
  logic                                 s5_v;
  logic signed [ptsd_pkg::FOOT_W-1:0]   s5_fx, s5_fy;
  logic signed [DW-1:0]                 s5_ax, s5_ay, s5_bx, s5_by;
  ptsd_pkg::region_t                    s5_region;
  logic signed [ptsd_pkg::T_W:0]        t_s;

  assign t_s = ds.eq ? (ptsd_pkg::T_W + 1)'(1 << FB) : {2'b00, dq};

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_fx     <= t_s * ds.dx;
      s5_fy     <= t_s * ds.dy;
      s5_ax     <= ds.ax;
      s5_ay     <= ds.ay;
      s5_bx     <= ds.bx;
      s5_by     <= ds.by;
      s5_region <= ds.region;
    end
  end

  // stage 6: error vector
  localparam int EW = ptsd_pkg::ERR_W;

  logic                  s6_v;
  logic [EW-1:0]         s6_ex, s6_ey;
  ptsd_pkg::region_t     s6_region;
  logic [EW-1:0]         ex_next, ey_next;
  logic [EW-1:0]         ax_e, ay_e, bx_e, by_e, fx_e, fy_e;

  assign ax_e = {{(EW - DW){s5_ax[DW-1]}}, s5_ax};
  assign ay_e = {{(EW - DW){s5_ay[DW-1]}}, s5_ay};
  assign bx_e = {{(EW - DW){s5_bx[DW-1]}}, s5_bx};
  assign by_e = {{(EW - DW){s5_by[DW-1]}}, s5_by};
  assign fx_e = {s5_fx[ptsd_pkg::FOOT_W-1], s5_fx[ptsd_pkg::FOOT_W-1:FB]};
  assign fy_e = {s5_fy[ptsd_pkg::FOOT_W-1], s5_fy[ptsd_pkg::FOOT_W-1:FB]};

  always_comb begin
    unique case (s5_region)
      ptsd_pkg::REG_FOOT: begin
        ex_next = ax_e - fx_e;
        ey_next = ay_e - fy_e;
      end
      ptsd_pkg::REG_END: begin
        ex_next = bx_e;
        ey_next = by_e;
      end
      default: begin
        ex_next = ax_e;
        ey_next = ay_e;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ex     <= ex_next;
      s6_ey     <= ey_next;
      s6_region <= s5_region;
    end
  end

  // stage 7: squares
  logic                          s7_v;
  logic [ptsd_pkg::SQ_W-1:0]     s7_sx, s7_sy;
  ptsd_pkg::region_t             s7_region;
  logic [EW-1:0]                 mx, my;

  assign mx = s6_ex[EW-1] ? -s6_ex : s6_ex;
  assign my = s6_ey[EW-1] ? -s6_ey : s6_ey;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_sx     <= mx * mx;
      s7_sy     <= my * my;
      s7_region <= s6_region;
    end
  end

  // stage 8: sum of squares
  logic                          s8_v;
  logic [ptsd_pkg::RAD_W-1:0]    s8_rad;
  ptsd_pkg::region_t             s8_region;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_rad    <= {2'b00, s7_sx} + {2'b00, s7_sy};
      s8_region <= s7_region;
    end
  end

  logic                          qv;
  logic [ptsd_pkg::ROOT_W-1:0]   qroot;
  ptsd_pkg::region_t             qregion;

  ptsd_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s8_v),
    .in_rad     (s8_rad),
    .in_region  (s8_region),
    .out_valid  (qv),
    .out_root   (qroot),
    .out_region (qregion)
  );

  // output register, saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= qv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      distance       <= (qroot[ptsd_pkg::ROOT_W-1:ptsd_pkg::DIST_W] != '0) ?
                        '1 : qroot[ptsd_pkg::DIST_W-1:0];
      nearest_region <= qregion;
    end
  end

`ifndef ASSERT_OFF
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_degen_only_zero_len: assert property (@(posedge clk) disable iff (rst)
    (s4_v && s4_side.region == ptsd_pkg::REG_DEGEN) |->
      (s4_side.dx == '0 && s4_side.dy == '0))
    else $error("degenerate region with nonzero segment");

  a_endpoint_is_foot: assert property (@(posedge clk) disable iff (rst)
    (s4_v && s4_side.eq && s4_side.region != ptsd_pkg::REG_DEGEN) |->
      s4_side.region == ptsd_pkg::REG_FOOT)
    else $error("projection at end point not classified as foot");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(s4_v) && $stable(qv)))
    else $error("pipeline advanced while output stalled");
`endif

endmodule
